[rtl/pwli_pkg.sv]
package pwli_pkg;

    // Field widths
    localparam int TIME_W      = 32;
    localparam int FACTOR_W    = 24;
    localparam int IDX_FIELD_W = 10;
    localparam int COUNT_W     = 11;

    // Table storage
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Serial arithmetic widths
    localparam int DT_W      = TIME_W + 1;
    localparam int DF_W      = FACTOR_W + 1;
    localparam int PROD_W    = DT_W + DF_W;
    localparam int DVS_W     = DT_W + 1;
    localparam int QM_W      = FACTOR_W + 1;
    localparam int MUL_STEPS = DF_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_W    = $clog2(PROD_W);
    localparam int RES_W     = FACTOR_W + 2;

    // Factor constants, Q8.16
    localparam logic signed [FACTOR_W-1:0] FACTOR_ONE = 24'sh010000;
    localparam logic signed [FACTOR_W-1:0] FACTOR_MAX = 24'sh7FFFFF;
    localparam logic signed [FACTOR_W-1:0] FACTOR_MIN = 24'sh800000;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd2;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_CALC,
        ST_DONE
    } pwli_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_LOAD,
        MD_DIV
    } md_state_t;

    typedef struct packed {
        logic done;
        logic neg;
    } md_status_t;

endpackage

[rtl/pwli_if.sv]
interface pwli_item_if import pwli_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [IDX_FIELD_W-1:0]     entry_index;
    logic signed [TIME_W-1:0]   entry_time;
    logic signed [FACTOR_W-1:0] entry_factor;
    logic signed [TIME_W-1:0]   query_time;

    modport source (output valid, opcode, entry_index, entry_time, entry_factor,
                    query_time, input ready);
    modport sink   (input valid, opcode, entry_index, entry_time, entry_factor,
                    query_time, output ready);
endinterface

interface pwli_result_if import pwli_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [FACTOR_W-1:0] flux_factor;
    logic                       in_table;

    modport source (output valid, flux_factor, in_table, input ready);
    modport sink   (input valid, flux_factor, in_table, output ready);
endinterface

interface pwli_cfg_if import pwli_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/pwli_muldiv.sv]
module pwli_muldiv import pwli_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DF_W-1:0]  df,
    input  logic signed [DT_W-1:0]  dq,
    input  logic signed [DT_W-1:0]  den,
    output md_status_t              status,
    output logic [QM_W-1:0]         qm
);

    md_state_t             state_reg, state_next;
    logic [STEP_W-1:0]     cnt_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [DT_W-1:0]       mcand_reg;
    logic [DT_W-1:0]       den_mag_reg;
    logic [DVS_W-1:0]      dvs_reg;
    logic [DVS_W-1:0]      rem_reg;
    logic [QM_W-1:0]       q_reg;
    logic                  ovf_reg;
    logic                  neg_reg;
    logic                  done_reg;

    logic [DT_W:0]         mul_sum;
    logic [DVS_W:0]        r_sh;
    logic [DVS_W+1:0]      r_diff;
    logic                  r_ge;

    // Shift-add step: one multiplier bit per cycle
    assign mul_sum = {1'b0, prod_reg[PROD_W-1:DF_W]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : {(DT_W+1){1'b0}});

    // Restoring divide step: one quotient bit per cycle
    assign r_sh   = {rem_reg, prod_reg[PROD_W-1]};
    assign r_diff = {1'b0, r_sh} - {2'b00, dvs_reg};
    assign r_ge   = !r_diff[DVS_W+1];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                    state_next = MD_MUL;
            end
            MD_MUL:
            begin
                if (cnt_reg == '0)
                    state_next = MD_LOAD;
            end
            MD_LOAD:
                state_next = MD_DIV;
            MD_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = MD_IDLE;
            end
            default:
                state_next = MD_IDLE;
        endcase
    end

    // Outputs: clamp the quotient once it cannot fit a factor step
    always_comb
    begin
        status.done = done_reg;
        status.neg  = neg_reg;
        if (ovf_reg || q_reg[QM_W-1])
            qm = {1'b1, {(QM_W-1){1'b0}}};
        else
            qm = q_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MD_DIV) && (cnt_reg == '0);
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    mcand_reg   <= dq[DT_W-1] ? DT_W'(-dq) : DT_W'(dq);
                    den_mag_reg <= den[DT_W-1] ? DT_W'(-den) : DT_W'(den);
                    dvs_reg     <= den[DT_W-1] ? {DT_W'(-den), 1'b0} : {DT_W'(den), 1'b0};
                    prod_reg    <= {{DT_W{1'b0}},
                                    (df[DF_W-1] ? DF_W'(-df) : DF_W'(df))};
                    neg_reg     <= df[DF_W-1] ^ dq[DT_W-1] ^ den[DT_W-1];
                    cnt_reg     <= STEP_W'(MUL_STEPS - 1);
                end
            end
            MD_MUL:
            begin
                prod_reg <= {mul_sum, prod_reg[DF_W-1:1]};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            MD_LOAD:
            begin
                // dividend = 2|num| + |den|, divisor = 2|den|
                prod_reg <= {prod_reg[PROD_W-2:0], 1'b0} + PROD_W'(den_mag_reg);
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
                cnt_reg  <= STEP_W'(DIV_STEPS - 1);
            end
            MD_DIV:
            begin
                rem_reg  <= r_ge ? r_diff[DVS_W-1:0] : r_sh[DVS_W-1:0];
                prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                q_reg    <= {q_reg[QM_W-2:0], r_ge};
                ovf_reg  <= ovf_reg | q_reg[QM_W-1];
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == MD_IDLE)
        else $error("muldiv started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("muldiv done held for more than one cycle");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MD_DIV |-> rem_reg < dvs_reg)
        else $error("partial remainder not below divisor");

endmodule

[rtl/piecewise_linear_table_interp_unit.sv]
// Load word: written straight into the entry memories; loads follow back to back.
// Query word: a scan up to the bracketing entry, a prepare step, a 25-step shift-add
// multiply and a 58-step restoring divide, then a finish step that loads the result word;
// equal times skip the muldiv, and a miss or fewer than two entries go straight to the finish step.
// One query at a time: the next word is taken the cycle after its result word is loaded.
// Reset clears control state and the output valid and sets entry_count to 2; memories stay as is.
module piecewise_linear_table_interp_unit import pwli_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    pwli_item_if.sink      item,
    pwli_result_if.source  result,
    pwli_cfg_if.sink       cfg
);

    // Entry memories
    logic signed [TIME_W-1:0]   time_mem   [TABLE_DEPTH];
    logic signed [FACTOR_W-1:0] factor_mem [TABLE_DEPTH];

    pwli_state_t                state_reg, state_next;
    logic [COUNT_W-1:0]         entry_count_reg;
    logic [CNT_W-1:0]           lim_reg;
    logic [CNT_W-1:0]           addr_reg;
    logic [CNT_W-1:0]           rd_idx_reg;
    logic                       rd_vld_reg;
    logic signed [TIME_W-1:0]   q_reg;
    logic signed [TIME_W-1:0]   t_rd_reg;
    logic signed [FACTOR_W-1:0] f_rd_reg;
    logic signed [TIME_W-1:0]   t_prev_reg;
    logic signed [FACTOR_W-1:0] f_prev_reg;
    logic signed [FACTOR_W-1:0] f1_reg;
    logic signed [DT_W-1:0]     den_reg;
    logic signed [DT_W-1:0]     dq_reg;
    logic signed [DF_W-1:0]     df_reg;
    logic signed [FACTOR_W-1:0] res_reg;
    logic                       found_reg;
    logic                       out_valid_reg;
    logic signed [FACTOR_W-1:0] flux_reg;
    logic                       in_table_reg;

    logic                       accept;
    logic                       load_en;
    logic                       query_en;
    logic [CNT_W-1:0]           lim_calc;
    logic                       hit;
    logic                       miss_end;
    logic                       out_load;
    logic                       md_start;
    md_status_t                 md_status;
    logic [QM_W-1:0]            md_qm;
    logic signed [RES_W-1:0]    sum;
    logic signed [FACTOR_W-1:0] sat;

    assign accept   = item.valid && item.ready;
    assign load_en  = accept && (item.opcode == OP_LOAD)
                   && (32'(item.entry_index) < TABLE_DEPTH);
    assign query_en = accept && (item.opcode == OP_QUERY);

    // Limit the scan to the table depth
    assign lim_calc = (32'(entry_count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                            : CNT_W'(entry_count_reg);

    // First entry from 1 upward at or after the query time
    assign hit      = (state_reg == ST_SCAN) && rd_vld_reg && (rd_idx_reg != '0)
                   && (t_rd_reg >= q_reg);
    assign miss_end = (state_reg == ST_SCAN) && rd_vld_reg && !hit
                   && (rd_idx_reg == lim_reg - CNT_W'(1));

    // Add the rounded step to the earlier factor and saturate
    assign sum = md_status.neg ? (RES_W'(f_prev_reg) - $signed({1'b0, md_qm}))
                               : (RES_W'(f_prev_reg) + $signed({1'b0, md_qm}));
    always_comb
    begin
        if (sum > RES_W'(FACTOR_MAX))
            sat = FACTOR_MAX;
        else if (sum < RES_W'(FACTOR_MIN))
            sat = FACTOR_MIN;
        else
            sat = sum[FACTOR_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_en)
                    state_next = (lim_calc < CNT_W'(2)) ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (hit)
                    state_next = ST_PREP;
                else if (miss_end)
                    state_next = ST_DONE;
            end
            ST_PREP:
                state_next = (den_reg == '0) ? ST_DONE : ST_CALC;
            ST_CALC:
            begin
                if (md_status.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        item.ready         = (state_reg == ST_IDLE);
        cfg.ready          = 1'b1;
        md_start           = (state_reg == ST_PREP) && (den_reg != '0);
        out_load           = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
        result.valid       = out_valid_reg;
        result.flux_factor = flux_reg;
        result.in_table    = in_table_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= ENTRY_COUNT_RESET;
            out_valid_reg   <= 1'b0;
            rd_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_SCAN) && (addr_reg < lim_reg);
            if (cfg.valid && cfg.ready)
                entry_count_reg <= cfg.data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Entry memories: write on load, read every cycle at the scan address
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            time_mem[ADDR_W'(item.entry_index)]   <= item.entry_time;
            factor_mem[ADDR_W'(item.entry_index)] <= item.entry_factor;
        end
        t_rd_reg <= time_mem[addr_reg[ADDR_W-1:0]];
        f_rd_reg <= factor_mem[addr_reg[ADDR_W-1:0]];
    end

    // Scan and result datapath
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg;
        if (query_en)
        begin
            q_reg     <= item.query_time;
            lim_reg   <= lim_calc;
            addr_reg  <= '0;
            res_reg   <= FACTOR_ONE;
            found_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (addr_reg < lim_reg)
                addr_reg <= addr_reg + 1'b1;
            if (hit)
            begin
                den_reg   <= DT_W'(t_rd_reg) - DT_W'(t_prev_reg);
                dq_reg    <= DT_W'(q_reg) - DT_W'(t_prev_reg);
                df_reg    <= DF_W'(f_rd_reg) - DF_W'(f_prev_reg);
                f1_reg    <= f_rd_reg;
                found_reg <= 1'b1;
            end
            else if (rd_vld_reg)
            begin
                t_prev_reg <= t_rd_reg;
                f_prev_reg <= f_rd_reg;
            end
        end
        if ((state_reg == ST_PREP) && (den_reg == '0))
            res_reg <= f1_reg;
        if ((state_reg == ST_CALC) && md_status.done)
            res_reg <= sat;
        if (out_load)
        begin
            flux_reg     <= res_reg;
            in_table_reg <= found_reg;
        end
    end

    pwli_muldiv u_muldiv
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .df     (df_reg),
        .dq     (dq_reg),
        .den    (den_reg),
        .status (md_status),
        .qm     (md_qm)
    );

    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (rd_idx_reg != '0) && (rd_idx_reg < lim_reg))
        else $error("bracketing entry outside scanned range");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result word raised outside done state");

    a_default_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !in_table_reg) |-> flux_reg == FACTOR_ONE)
        else $error("default result is not 1.0");

endmodule
